>>> rtl/sha256_pkg.sv
// Package with the SHA-256 constants and helper functions shared by the hasher.
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;
   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned ROUNDS = 64;
   localparam int unsigned HASH_WORDS = 8;
   localparam int unsigned COUNT_WIDTH = 61;

   typedef logic [WORD_WIDTH-1:0] word_type;

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam word_type INITIAL_HASH [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] PAD_BYTE = 8'h80;

   function automatic word_type ror(input word_type v, input int unsigned s);
      ror = (v >> s) | (v << (WORD_WIDTH - s));
   endfunction

   function automatic word_type sig0(input word_type a);
      sig0 = ror(a, 7) ^ ror(a, 18) ^ (a >> 3);
   endfunction

   function automatic word_type sig1(input word_type b);
      sig1 = ror(b, 17) ^ ror(b, 19) ^ (b >> 10);
   endfunction
endpackage
`default_nettype wire

>>> rtl/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher: top level with byte packing, padding, compression and output.
// Usage: message bytes arrive on the req_ channel, one per transaction, with the
// byte in req_tdata, has_byte in req_tuser and end_of_message in req_tlast.
// The digest leaves on the rsp_ channel as eight transactions, word 0 first,
// with rsp_tlast on word 7 and the word index in rsp_tuser.
// A byte that does not complete a block passes an accept and a read-modify-write state.
// The 64th byte of a block starts a compression held in a 64-entry schedule RAM:
// 16 copy steps, 48 schedule steps, 64 rounds and a hash update.
// An end item writes the pad byte (after an extra read state when it follows a byte of
// the same transaction), zero-fills up to 15 words, runs one compression, or two
// when the length no longer fits (the second after a fill of all 16 words), and then
// presents the eight digest words, one per cycle while rsp_tready is high.
// The block word buffer and the schedule are synchronous RAMs that return read data in
// the cycle after the address; the hash and working variables are registers.
// A stalled receiver holds each digest word until rsp_tready; no new item is
// taken until the digest is out. Synchronous reset restores the initial hash
// and a zero byte count; the RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // data_byte[7:0]
   input  wire logic        req_tuser,  // has_byte
   input  wire logic        req_tlast,  // end_of_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // digest_word[31:0]
   output logic             rsp_tlast,  // last_word
   output logic [2:0]       rsp_tuser   // word_index[2:0]
);
   import sha256_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_BYTE  = 4'd1;
   localparam logic [3:0] ST_PAD   = 4'd2;
   localparam logic [3:0] ST_PADW  = 4'd3;
   localparam logic [3:0] ST_LEN   = 4'd4;
   localparam logic [3:0] ST_COPY  = 4'd5;
   localparam logic [3:0] ST_SCHED = 4'd6;
   localparam logic [3:0] ST_ROUND = 4'd7;
   localparam logic [3:0] ST_ADD   = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;
   localparam logic [3:0] ST_PADR  = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   word_type    hash_ff [HASH_WORDS];
   word_type    hash_in [HASH_WORDS];
   word_type    var_ff [HASH_WORDS];
   word_type    var_in [HASH_WORDS];
   logic [7:0]  byte_ff, byte_in;
   logic        fin_ff, fin_in;     // end of message pending after this block
   logic        lenblk_ff, lenblk_in; // current block carries the length
   logic [3:0]  pw_ff, pw_in;       // padding word pointer
   logic [6:0]  step_ff, step_in;   // copy/schedule/round counter
   logic [2:0]  sub_ff, sub_in;     // sub-phase within a step
   word_type    acc_ff, acc_in;
   logic [2:0]  oidx_ff, oidx_in;

   logic        bw_en;
   logic [3:0]  bw_addr, br_addr;
   word_type    bw_data, br_data;
   logic        sw_en;
   logic [5:0]  sw_addr, sr_addr;
   word_type    sw_data, sr_data;

   sha256_ram #(.WIDTH(WORD_WIDTH), .DEPTH(BLOCK_WORDS)) u_block (
      .clock(clock), .wr_en(bw_en), .wr_addr(bw_addr), .wr_data(bw_data),
      .rd_addr(br_addr), .rd_data(br_data));

   sha256_ram #(.WIDTH(WORD_WIDTH), .DEPTH(ROUNDS)) u_sched (
      .clock(clock), .wr_en(sw_en), .wr_addr(sw_addr), .wr_data(sw_data),
      .rd_addr(sr_addr), .rd_data(sr_data));

   logic [5:0] pos;
   logic [4:0] shift;
   word_type   merged, t1, t2;
   logic [63:0] bits;

   assign pos   = count_ff[5:0];
   assign shift = 5'd24 - {pos[1:0], 3'b000};
   assign bits  = {count_ff, 3'b000};

   always_comb begin
      merged = (pos[1:0] == 2'd0) ? '0 : br_data;
      merged = merged | (word_type'(byte_ff) << shift);
   end

   always_comb begin
      t1 = var_ff[7] + (ror(var_ff[4], 6) ^ ror(var_ff[4], 11) ^ ror(var_ff[4], 25))
         + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
         + ROUND_K[step_ff[5:0]] + sr_data;
      t2 = (ror(var_ff[0], 2) ^ ror(var_ff[0], 13) ^ ror(var_ff[0], 22))
         + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = hash_ff[oidx_ff];
   assign rsp_tuser  = oidx_ff;
   assign rsp_tlast  = (oidx_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      hash_in  = hash_ff;
      var_in   = var_ff;
      byte_in  = byte_ff;
      fin_in   = fin_ff;
      lenblk_in = lenblk_ff;
      pw_in    = pw_ff;
      step_in  = step_ff;
      sub_in   = sub_ff;
      acc_in   = acc_ff;
      oidx_in  = oidx_ff;
      bw_en = 1'b0; bw_addr = pos[5:2]; bw_data = merged; br_addr = pos[5:2];
      sw_en = 1'b0; sw_addr = step_ff[5:0]; sw_data = br_data; sr_addr = step_ff[5:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               fin_in = req_tlast;
               lenblk_in = 1'b0;
               if (req_tuser) begin
                  byte_in = req_tdata;
                  state_in = ST_BYTE;
               end else if (req_tlast) begin
                  byte_in = PAD_BYTE;
                  state_in = ST_PAD;
               end
            end
         end
         ST_BYTE: begin
            bw_en = 1'b1;
            count_in = count_ff + 1'b1;
            if (pos == 6'd63) begin
               state_in = ST_COPY; step_in = '0; sub_in = '0;
            end else if (fin_ff) begin
               byte_in = PAD_BYTE; state_in = ST_PADR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PADR: begin
            // The word just written is read back here before the pad byte is merged.
            state_in = ST_PAD;
         end
         ST_PAD: begin
            // read of the partial word was issued last cycle by default addr
            bw_en = 1'b1;
            pw_in = pos[5:2] + 1'b1;
            state_in = (pos[5:2] == 4'd15) ? ST_PADW : ST_PADW;
            if (pos[5:2] == 4'd15) begin
               if (pos >= 6'd56) state_in = ST_COPY;
            end
            if (pos >= 6'd56 && pos[5:2] == 4'd15) begin
               step_in = '0; sub_in = '0;
            end
         end
         ST_PADW: begin
            bw_addr = pw_ff; bw_data = '0;
            if (lenblk_ff || pos < 6'd56) begin
               if (pw_ff == 4'd14) bw_data = bits[63:32];
               if (pw_ff == 4'd15) bw_data = bits[31:0];
            end
            bw_en = 1'b1;
            pw_in = pw_ff + 1'b1;
            if (pw_ff == 4'd15) begin
               state_in = ST_COPY; step_in = '0; sub_in = '0;
               if (pos < 6'd56) lenblk_in = 1'b1;
            end
         end
         ST_COPY: begin
            br_addr = step_ff[3:0];
            if (sub_ff == 3'd0) begin
               sub_in = 3'd1;
            end else begin
               sw_en = 1'b1;
               sw_addr = step_ff[5:0];
               sw_data = br_data;
               sub_in = 3'd0;
               step_in = step_ff + 1'b1;
               if (step_ff == 7'd15) state_in = ST_SCHED;
            end
         end
         ST_SCHED: begin
            // four reads: r-16, r-15, r-7, r-2, accumulated
            case (sub_ff)
               3'd0: sr_addr = 6'(step_ff - 7'd16);
               3'd1: sr_addr = 6'(step_ff - 7'd15);
               3'd2: sr_addr = 6'(step_ff - 7'd7);
               3'd3: sr_addr = 6'(step_ff - 7'd2);
               default: sr_addr = 6'(step_ff - 7'd2);
            endcase
            case (sub_ff)
               3'd0: sub_in = 3'd1;
               3'd1: begin acc_in = sr_data; sub_in = 3'd2; end
               3'd2: begin acc_in = acc_ff + sig0(sr_data); sub_in = 3'd3; end
               3'd3: begin acc_in = acc_ff + sr_data; sub_in = 3'd4; end
               default: begin
                  sw_en = 1'b1;
                  sw_data = acc_ff + sig1(sr_data);
                  sub_in = 3'd0;
                  step_in = step_ff + 1'b1;
                  if (step_ff == 7'd63) begin
                     state_in = ST_ROUND; step_in = '0;
                     var_in = hash_ff;
                  end
               end
            endcase
         end
         ST_ROUND: begin
            sr_addr = step_ff[5:0];
            if (sub_ff == 3'd0) begin
               sub_in = 3'd1;
            end else begin
               var_in[7] = var_ff[6]; var_in[6] = var_ff[5]; var_in[5] = var_ff[4];
               var_in[4] = var_ff[3] + t1;
               var_in[3] = var_ff[2]; var_in[2] = var_ff[1]; var_in[1] = var_ff[0];
               var_in[0] = t1 + t2;
               sub_in = 3'd0;
               step_in = step_ff + 1'b1;
               if (step_ff == 7'd63) state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < HASH_WORDS; i++) hash_in[i] = hash_ff[i] + var_ff[i];
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (lenblk_ff) begin
               state_in = ST_OUT; oidx_in = '0;
            end else if (pos == 6'd0) begin
               // The message ended on a block boundary: padding starts a fresh block.
               byte_in = PAD_BYTE; state_in = ST_PAD;
            end else begin
               // second block after padding overflow: zero words, length
               lenblk_in = 1'b1; pw_in = '0; state_in = ST_PADW;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               oidx_in = oidx_ff + 1'b1;
               if (oidx_ff == 3'd7) begin
                  hash_in = INITIAL_HASH;
                  count_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         hash_ff  <= INITIAL_HASH;
         fin_ff   <= 1'b0;
         lenblk_ff <= 1'b0;
         oidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         hash_ff  <= hash_in;
         fin_ff   <= fin_in;
         lenblk_ff <= lenblk_in;
         oidx_ff  <= oidx_in;
      end
      var_ff  <= var_in;
      byte_ff <= byte_in;
      pw_ff   <= pw_in;
      step_ff <= step_in;
      sub_ff  <= sub_in;
      acc_ff  <= acc_in;
   end
endmodule
`default_nettype wire

>>> rtl/sha256_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module sha256_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire
